### hdl/bffa_pkg.sv
// shared constants, codes and controller/datapath interface types of the bitmap allocator
package bffa_pkg;

  localparam int MAP_ENTRIES = 65536;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int IDX_W       = 16;
  localparam int CNT_W       = 17;
  localparam int REG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(65536);
  localparam logic [CNT_W-1:0] FREE_RST =
    (ENTRY_COUNT_RST > CNT_W'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : ENTRY_COUNT_RST;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_MARK  = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_START = 1'b1;

  typedef struct packed {
    logic clear_step;    // zero one map word during the clearing pass
    logic start_read;    // latch request, read its first word
    logic scan_step;     // read the next word of an allocate scan
    logic finish_alloc;  // set the found bit, load a granted result
    logic finish_mark;   // set the marked bit, load a granted result
    logic fail;          // load a result with granted clear
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;    // clearing pass is at its last word
    logic alloc_ok;      // search start lies below the entry count
    logic mark_ok;       // incoming mark index lies below the entry count
    logic hit;           // current word holds a free bit in range
    logic last;          // current word holds the last entry in use
  } dp_status_t;

endpackage

### hdl/bitmap_first_free_allocator_unit.sv
// top level of the bitmap first-free allocator: controller plus bitmap datapath
// After reset the block runs a clearing pass over the bitmap, one 32-bit word per
// cycle, and takes no word until it ends; configuration writes are taken
// throughout. A mark request is accepted, reads its bitmap word through one
// registered read of the bitmap memory, and then loads its result. An allocate
// reads the word holding search_start and then scans the following map words
// until a free bit or the end of the entry range is found; the single memory read
// port reads one word per cycle. A start at or past the entry count fails without a
// read: its result is loaded at the accepting edge. Results sit in an
// output register, so the next request is taken in the cycle the result is taken.
// Config writes are only allowed while no request is outstanding.
module bitmap_first_free_allocator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bffa_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [bffa_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // [15:0] mark_index
  input  logic                             s_axis_tuser,   // [0] op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata,   // [15:0] entry_index, [32:16] free_left
  output logic                             m_axis_tuser    // [0] granted
);
  import bffa_pkg::*;

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic               out_granted;
  logic [IDX_W-1:0]   out_index;
  logic [CNT_W-1:0]   out_free;

  bffa_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  bffa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (s_axis_tuser),
    .in_mark_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_granted_o (out_granted),
    .out_index_o   (out_index),
    .out_free_o    (out_free)
  );

  assign m_axis_tdata = {7'd0, out_free, out_index};
  assign m_axis_tuser = out_granted;

endmodule

### hdl/bffa_datapath.sv
// bitmap memory, free counter, configuration registers and result register
module bffa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bffa_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [bffa_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                in_op_i,
  input  logic [bffa_pkg::IDX_W-1:0]          in_mark_i,
  input  bffa_pkg::dp_cmd_t                   cmd_i,
  output bffa_pkg::dp_status_t                status_o,
  output logic                                out_granted_o,
  output logic [bffa_pkg::IDX_W-1:0]          out_index_o,
  output logic [bffa_pkg::CNT_W-1:0]          out_free_o
);
  import bffa_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [CNT_W-1:0]   entry_count_q;
  logic [IDX_W-1:0]   search_start_q;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [WORD_AW-1:0] clr_ptr_q;
  logic [WORD_AW-1:0] rd_word_q, rd_word_d;
  logic [IDX_W-1:0]   mark_q;

  logic               out_granted_q;
  logic [IDX_W-1:0]   out_index_q;
  logic [CNT_W-1:0]   out_free_q;

  logic [CNT_W-1:0]     limit, limit_m1, cfg_limit, free_dec;
  logic [WORD_AW-1:0]   start_word, last_word, raddr, waddr;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, hi_tmp, free_vec, first_hot, mark_hot, wdata;
  logic [BIT_AW-1:0]    first_pos;
  logic                 we, mark_was_free;

  assign limit     = (entry_count_q > CNT_W'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : entry_count_q;
  assign cfg_limit = (cfg_wdata_i > CNT_W'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : cfg_wdata_i;
  assign limit_m1  = limit - CNT_W'(1);
  assign start_word = search_start_q[IDX_W-1:BIT_AW];
  assign last_word  = limit_m1[IDX_W-1:BIT_AW];
  assign free_dec   = (free_q == '0) ? '0 : free_q - CNT_W'(1);

  // window the word to [search_start, entry_count)
  assign lo_mask  = (rd_word_q == start_word) ?
                    ({WORD_BITS{1'b1}} << search_start_q[BIT_AW-1:0]) : {WORD_BITS{1'b1}};
  assign hi_tmp   = {WORD_BITS{1'b1}} << limit_m1[BIT_AW-1:0];
  assign hi_mask  = (rd_word_q == last_word) ? ~(hi_tmp << 1) : {WORD_BITS{1'b1}};
  assign free_vec = ~rdata_q & lo_mask & hi_mask;
  assign first_hot = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    first_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (first_hot[i]) first_pos = first_pos | BIT_AW'(i);
    end
  end

  assign mark_hot      = WORD_BITS'(1) << mark_q[BIT_AW-1:0];
  assign mark_was_free = ~rdata_q[mark_q[BIT_AW-1:0]];

  assign status_o.clear_done = (clr_ptr_q == WORD_AW'(MAP_WORDS - 1));
  assign status_o.alloc_ok   = ({1'b0, search_start_q} < limit);
  assign status_o.mark_ok    = ({1'b0, in_mark_i} < limit);
  assign status_o.hit        = |free_vec;
  assign status_o.last       = (rd_word_q == last_word);

  always_comb begin
    rd_word_d = rd_word_q;
    if (cmd_i.start_read) begin
      rd_word_d = (in_op_i == OP_ALLOC) ? start_word : in_mark_i[IDX_W-1:BIT_AW];
    end else if (cmd_i.scan_step) begin
      rd_word_d = rd_word_q + WORD_AW'(1);
    end
  end
  assign raddr = rd_word_d;

  always_comb begin
    we    = cmd_i.clear_step | cmd_i.finish_alloc | cmd_i.finish_mark;
    waddr = cmd_i.clear_step ? clr_ptr_q : rd_word_q;
    if (cmd_i.clear_step) begin
      wdata = '0;
    end else if (cmd_i.finish_alloc) begin
      wdata = rdata_q | first_hot;
    end else begin
      wdata = rdata_q | mark_hot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    free_d = free_q;
    if (cfg_we_i && cfg_index_i == REG_ENTRY_COUNT) begin
      free_d = cfg_limit;
    end else if (cmd_i.finish_alloc || (cmd_i.finish_mark && mark_was_free)) begin
      free_d = free_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q  <= ENTRY_COUNT_RST;
      search_start_q <= '0;
      free_q         <= FREE_RST;
      clr_ptr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENTRY_COUNT:  entry_count_q  <= cfg_wdata_i;
          REG_SEARCH_START: search_start_q <= cfg_wdata_i[IDX_W-1:0];
          default: ;
        endcase
      end
      free_q <= free_d;
      if (cmd_i.clear_step) clr_ptr_q <= clr_ptr_q + WORD_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= rd_word_d;
    if (cmd_i.start_read) mark_q <= in_mark_i;
    if (cmd_i.finish_alloc) begin
      out_granted_q <= 1'b1;
      out_index_q   <= {rd_word_q, first_pos};
      out_free_q    <= free_d;
    end else if (cmd_i.finish_mark) begin
      out_granted_q <= 1'b1;
      out_index_q   <= mark_q;
      out_free_q    <= free_d;
    end else if (cmd_i.fail) begin
      out_granted_q <= 1'b0;
      out_index_q   <= '0;
      out_free_q    <= free_q;
    end
  end

  assign out_granted_o = out_granted_q;
  assign out_index_o   = out_index_q;
  assign out_free_o    = out_free_q;

`ifndef SYNTH
  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= limit)
    else $error("free count above entry count");
  a_alloc_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_alloc |-> |free_vec)
    else $error("allocate committed without a free bit");
  a_scan_not_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> rd_word_q != last_word)
    else $error("scan stepped past the last word");
`endif

endmodule

### hdl/bffa_controller.sv
// request sequencer: clearing pass, allocate scan, mark update and result handshake
module bffa_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bffa_pkg::dp_cmd_t     cmd_o,
  input  bffa_pkg::dp_status_t  status_i
);
  import bffa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_MARK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, load;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_ALLOC) begin
            if (status_i.alloc_ok) begin
              cmd_o.start_read = 1'b1;
              state_d          = S_SCAN;
            end else begin
              cmd_o.fail = 1'b1;
            end
          end else begin
            if (status_i.mark_ok) begin
              cmd_o.start_read = 1'b1;
              state_d          = S_MARK;
            end else begin
              cmd_o.fail = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (status_i.hit) begin
          cmd_o.finish_alloc = 1'b1;
          state_d            = S_IDLE;
        end else if (status_i.last) begin
          cmd_o.fail = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MARK: begin
        cmd_o.finish_mark = 1'b1;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign load = cmd_o.finish_alloc | cmd_o.finish_mark | cmd_o.fail;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("word accepted during clearing pass");
  a_out_free_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_MARK) |-> !out_valid_q)
    else $error("result register occupied while a request is at work");
  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clear_step, cmd_o.start_read, cmd_o.scan_step,
              cmd_o.finish_alloc, cmd_o.finish_mark, cmd_o.fail}))
    else $error("more than one datapath command");
`endif

endmodule
